FILE: hdl/per_source_leaky_bucket_limiter_top_defines.svh
// Assertion macros for the leaky bucket limiter
`ifndef PER_SOURCE_LEAKY_BUCKET_LIMITER_TOP_DEFINES_SVH
`define PER_SOURCE_LEAKY_BUCKET_LIMITER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PSLB_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define PSLB_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define PSLB_ASSERT_IMPL(label, clk, rst_n, a, c)
`define PSLB_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: hdl/pslb_pkg.sv
`timescale 1ns / 1ps
package pslb_pkg;
	typedef enum logic [1:0] {
		VERDICT_ADMIT     = 2'd0,
		VERDICT_FULL      = 2'd1,
		VERDICT_EXHAUSTED = 2'd2
	} verdict_t;

	localparam int unsigned TOKEN_MAX = 65535;

	// divider handshake
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [16:0] rem;
	} div_rsp_t;
endpackage

FILE: hdl/pslb_ram.sv
`timescale 1ns / 1ps
module pslb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hdl/pslb_div.sv
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit a cycle.
module pslb_div (
	input  logic             clk,
	input  logic             arst_n,
	input  pslb_pkg::div_req_t req,
	output pslb_pkg::div_rsp_t rsp
);
	import pslb_pkg::*;

	logic [31:0] quot_q;
	logic [17:0] rem_q;
	logic [16:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] trial;

	always_comb begin
		trial = {rem_q[16:0], quot_q[31]} - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
				quot_q <= req.dividend;
				rem_q  <= '0;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				if (!trial[17]) begin
					rem_q  <= trial;
					quot_q <= {quot_q[30:0], 1'b1};
				end else begin
					rem_q  <= {rem_q[16:0], quot_q[31]};
					quot_q <= {quot_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q[16:0];
endmodule

FILE: hdl/per_source_leaky_bucket_limiter_top.sv
`timescale 1ns / 1ps
`include "per_source_leaky_bucket_limiter_top_defines.svh"
// Leaky bucket limiter: one request at a time. A per-source request scans the
// pool slot memories one entry at a time, with a read state and a check state
// per entry, first for a live matching address and then for a free or expired
// slot; the bucket drain then runs a bit-serial divider. Global bucket and
// pass-through requests skip the scan. The verdict is held in an output
// register; the next item is taken once it has been delivered.
module per_source_leaky_bucket_limiter_top #(
	parameter int POOL_SLOTS     = 256,
	parameter int SHARED_BUCKETS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [31:0] now_ms,
	input  logic [31:0] src_ip,
	input  logic        is_ipv4,
	input  logic        is_lan,
	input  logic [3:0]  global_index,
	input  logic [15:0] burst_limit,
	input  logic [16:0] period_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  verdict
);
	import pslb_pkg::*;

	localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int GW = (SHARED_BUCKETS > 1) ? $clog2(SHARED_BUCKETS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MATCH_RD, ST_MATCH_CHK, ST_FREE_RD, ST_FREE_CHK,
		ST_LOAD, ST_DIV_GO, ST_DIV_WAIT, ST_UPDATE, ST_OUT
	} state_t;

	state_t      state_q;
	logic        enable_q;
	logic        mode_q;
	logic [31:0] now_q, ip_q;
	logic [15:0] burst_q;
	logic [16:0] period_q;
	logic [GW-1:0] gidx_q;
	logic [AW:0]   idx_q;
	logic [AW-1:0] pick_q;
	logic [POOL_SLOTS-1:0] live_q;
	logic [31:0] stamp_q;
	logic [15:0] tok_q;
	logic        neg_q;
	logic [32:0] limit_q;
	logic [1:0]  verdict_q;
	logic [31:0] sh_stamp_q [SHARED_BUCKETS];
	logic [15:0] sh_tok_q [SHARED_BUCKETS];

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   addr_wd, stamp_wd, addr_rd, stamp_rd;
	logic [15:0]   tok_wd, tok_rd;

	div_req_t dreq;
	div_rsp_t drsp;

	pslb_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_addr (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(addr_wd),
		.raddr(ram_raddr), .rdata(addr_rd));
	pslb_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_stamp (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(stamp_wd),
		.raddr(ram_raddr), .rdata(stamp_rd));
	pslb_ram #(.WIDTH(16), .DEPTH(POOL_SLOTS)) u_tok (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(tok_wd),
		.raddr(ram_raddr), .rdata(tok_rd));

	pslb_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// interval now - stamp, signed
	logic [31:0] iv_scan, iv_cur, iv_abs;
	logic [32:0] lim_prod;
	logic        expire_hit;
	assign iv_scan   = now_q - stamp_rd;
	assign iv_cur    = now_q - stamp_q;
	assign iv_abs    = iv_cur[31] ? (32'd0 - iv_cur) : iv_cur;
	assign lim_prod  = 33'(burst_q) * 33'((period_q == '0) ? 17'd1 : period_q);
	assign expire_hit = !iv_scan[31] && ({1'b0, iv_scan} > limit_q);

	// drain arithmetic after division
	logic [17:0] tok_next, tok_sat;
	logic [32:0] exp_mag;
	logic        drain_all;
	logic [31:0] stamp_next;
	always_comb begin
		exp_mag   = {1'b0, drsp.quot};
		drain_all = 1'b0;
		tok_sat   = '0;
		if (!neg_q) begin
			drain_all = exp_mag > {17'd0, tok_q};
			tok_sat   = drain_all ? 18'd0 : 18'({1'b0, tok_q} - drsp.quot[16:0]);
		end else begin
			// negative expired raises tokens, saturate
			tok_sat = (exp_mag + {17'd0, tok_q} > 33'(TOKEN_MAX)) ? 18'(TOKEN_MAX)
				: 18'(exp_mag + {17'd0, tok_q});
		end
		if (drain_all) begin
			stamp_next = now_q;
		end else if (neg_q) begin
			stamp_next = now_q + {15'd0, drsp.rem};
		end else begin
			stamp_next = now_q - {15'd0, drsp.rem};
		end
		tok_next = ({2'b0, burst_q} > tok_sat) ? tok_sat + 18'd1 : tok_sat;
	end

	logic slot_mode;
	assign slot_mode = (mode_q == 1'b0);

	always_comb begin
		ram_raddr = idx_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = pick_q;
		addr_wd   = ip_q;
		stamp_wd  = stamp_next;
		tok_wd    = tok_next[15:0];
		if (state_q == ST_UPDATE && slot_mode) begin
			ram_we = 1'b1;
		end
		dreq.start    = (state_q == ST_DIV_GO);
		dreq.dividend = iv_abs;
		dreq.divisor  = (period_q == '0) ? 17'd1 : period_q;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign verdict   = verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			enable_q <= 1'b1;
			live_q   <= '0;
			for (int i = 0; i < SHARED_BUCKETS; i++) begin
				sh_stamp_q[i] <= '0;
				sh_tok_q[i]   <= '0;
			end
			verdict_q <= VERDICT_ADMIT;
			idx_q    <= '0;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q   <= mode;
						now_q    <= now_ms;
						ip_q     <= src_ip;
						burst_q  <= burst_limit;
						period_q <= period_ms;
						gidx_q   <= global_index[GW-1:0];
						idx_q    <= '0;
						verdict_q <= VERDICT_ADMIT;
						if (!enable_q) begin
							state_q <= ST_OUT;
						end else if (mode) begin
							if (32'(global_index) >= SHARED_BUCKETS) begin
								state_q <= ST_OUT;
							end else begin
								state_q <= ST_LOAD;
							end
						end else if (!is_ipv4 || is_lan) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_MATCH_RD;
						end
					end
				end
				ST_MATCH_RD: begin
					state_q <= ST_MATCH_CHK;
				end
				ST_MATCH_CHK: begin
					if (live_q[idx_q[AW-1:0]] && addr_rd == ip_q) begin
						pick_q  <= idx_q[AW-1:0];
						stamp_q <= stamp_rd;
						tok_q   <= tok_rd;
						state_q <= ST_DIV_GO;
					end else if (idx_q == (AW+1)'(POOL_SLOTS - 1)) begin
						idx_q   <= '0;
						limit_q <= lim_prod;
						state_q <= ST_FREE_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_MATCH_RD;
					end
				end
				ST_FREE_RD: begin
					state_q <= ST_FREE_CHK;
				end
				ST_FREE_CHK: begin
					if (!live_q[idx_q[AW-1:0]] || expire_hit) begin
						// take the slot fresh
						pick_q  <= idx_q[AW-1:0];
						live_q[idx_q[AW-1:0]] <= 1'b1;
						stamp_q <= now_q;
						tok_q   <= '0;
						state_q <= ST_DIV_GO;
					end else if (idx_q == (AW+1)'(POOL_SLOTS - 1)) begin
						verdict_q <= VERDICT_EXHAUSTED;
						state_q   <= ST_OUT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_FREE_RD;
					end
				end
				ST_LOAD: begin
					stamp_q <= sh_stamp_q[gidx_q];
					tok_q   <= sh_tok_q[gidx_q];
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					neg_q   <= iv_cur[31];
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (drsp.done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (!slot_mode) begin
						sh_stamp_q[gidx_q] <= stamp_next;
						sh_tok_q[gidx_q]   <= tok_next[15:0];
					end
					verdict_q <= ({2'b0, burst_q} > tok_sat) ? VERDICT_ADMIT : VERDICT_FULL;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PSLB_ASSERT_IMPL(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`PSLB_ASSERT_IMPL(a_verdict_code, clk, arst_n, out_valid, verdict != 2'd3)
	`PSLB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(verdict))
endmodule
